// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FCF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define FCF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/fcf_pkg.sv -----
package fcf_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int COEF_FRAC       = 16;
    localparam int CFG_WIDTH       = 23;
    localparam int QUOT_BITS       = COEF_FRAC + 1;

    localparam logic [22:0] HALF_EXTENT_RST = 23'd655360;
    localparam logic [16:0] STATIC_ROOT_RST = 17'd32768;
    localparam logic [16:0] KINETIC_ROOT_RST = 17'd32768;
    localparam logic [15:0] STILL_RST       = 16'd1;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_LIFT    = 2'd1,
        MODE_STATIC  = 2'd2,
        MODE_KINETIC = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_HALF_EXTENT  = 2'd0,
        CFG_STATIC_ROOT  = 2'd1,
        CFG_KINETIC_ROOT = 2'd2,
        CFG_STILL        = 2'd3
    } t_cfg_idx;

endpackage

// ----- hw/rtl/floor_contact_friction_unit.sv -----
// Floor contact with friction, one particle per transfer, one transfer per cycle
// while o_stall is low. Every item passes through the same stages: three front
// stages (lateral delta, squares and friction products, sum), one
// stage per result bit of the lateral-length square root (COORD_WIDTH + 2 bits,
// at most 32), one classify stage, seventeen quotient stages for the kinetic
// fraction, one product stage and the output register. The whole pipeline holds
// while a result waits under stall; o_stall is high only then.
module floor_contact_friction_unit
    import fcf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pred_x,
    input  logic signed [COORD_WIDTH-1:0] i_pred_y,
    input  logic signed [COORD_WIDTH-1:0] i_pred_z,
    input  logic signed [COORD_WIDTH-1:0] i_prev_x,
    input  logic signed [COORD_WIDTH-1:0] i_prev_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic [1:0]                    o_contact_mode,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [CFG_WIDTH-1:0]          i_cfg_wdata
);

    localparam int W   = COORD_WIDTH;
    localparam int HW  = ((W > 23) ? W : 23) + 2;
    localparam int A   = (W + 1 > 31) ? 31 : W + 1;
    localparam int L   = A + 1;
    localparam int SW  = 2 * A + 2;
    localparam int NW  = W + 17;
    localparam int DW  = NW + L;
    localparam int ST_D = 3 + L;
    localparam int ST_E = ST_D + QUOT_BITS + 1;
    localparam int NV  = ST_E + 2;
    localparam logic [W:0] AX_CAP = (W + 1)'((65'd1 << A) - 65'd1);

    typedef struct packed {
        logic                in_patch;
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] pz;
        logic signed [W-1:0] qx;
        logic signed [W-1:0] qz;
        logic signed [W:0]   dx;
        logic signed [W:0]   dz;
        logic [W-1:0]        lambda;
        logic [W:0]          slim;
        logic [NW-1:0]       num;
        logic [L-1:0]        len;
        logic [1:0]          mode;
        logic                sat;
    } t_carry;

    logic [22:0] r_half;
    logic [16:0] r_sroot;
    logic [16:0] r_kroot;
    logic [15:0] r_still;

    logic   en;
    logic   [NV-1:0] r_v;
    t_carry r_c [0:ST_E];
    t_carry n_c0, n_c1, n_c2, n_cd;

    logic [A-1:0]   r_ax, r_az;
    logic [2*A-1:0] r_sqx, r_sqz;
    logic [SW-1:0]  r_rem  [0:L];
    logic [L-1:0]   r_root [0:L];
    logic [NW-1:0]  r_drem [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] r_q [0:QUOT_BITS];
    logic [W+17:0]  r_pcx, r_pcz;
    logic signed [W-1:0] r_ox, r_oy, r_oz;
    logic [1:0]     r_mode;

    logic [W:0] n_axf, n_azf;

    assign en      = ~(r_v[NV-1] & i_stall);
    assign o_stall = ~en;
    assign o_valid = r_v[NV-1];
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_z = r_oz;
    assign o_contact_mode = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_EXTENT_RST;
            r_sroot <= STATIC_ROOT_RST;
            r_kroot <= KINETIC_ROOT_RST;
            r_still <= STILL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_HALF_EXTENT:  r_half  <= i_cfg_wdata;
                CFG_STATIC_ROOT:  r_sroot <= i_cfg_wdata[16:0];
                CFG_KINETIC_ROOT: r_kroot <= i_cfg_wdata[16:0];
                CFG_STILL:        r_still <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NV-2:0], i_valid};
        end
    end

    // stage a: patch test, lateral delta
    always_comb begin
        logic signed [HW-1:0] h;
        h = $signed(HW'(r_half));
        n_c0        = '0;
        n_c0.px     = i_pred_x;
        n_c0.py     = i_pred_y;
        n_c0.pz     = i_pred_z;
        n_c0.qx     = i_prev_x;
        n_c0.qz     = i_prev_z;
        n_c0.in_patch = (-h < HW'(i_pred_x)) && (HW'(i_pred_x) < h)
                     && (-h < HW'(i_pred_z)) && (HW'(i_pred_z) < h)
                     && i_pred_y[W-1];
        n_c0.lambda = W'(-i_pred_y);
        n_c0.dx     = (W + 1)'(i_pred_x) - (W + 1)'(i_prev_x);
        n_c0.dz     = (W + 1)'(i_pred_z) - (W + 1)'(i_prev_z);
        n_axf = n_c0.dx[W] ? (W + 1)'(-n_c0.dx) : n_c0.dx;
        n_azf = n_c0.dz[W] ? (W + 1)'(-n_c0.dz) : n_c0.dz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[0] <= n_c0;
            r_ax   <= (n_axf > AX_CAP) ? AX_CAP[A-1:0] : n_axf[A-1:0];
            r_az   <= (n_azf > AX_CAP) ? AX_CAP[A-1:0] : n_azf[A-1:0];
        end
    end

    // stage b: squares, static limit
    always_comb begin
        logic [W+16:0] sp;
        sp = (W + 17)'(r_sroot) * (W + 17)'(r_c[0].lambda);
        n_c1      = r_c[0];
        n_c1.slim = sp[W+16:COEF_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[1] <= n_c1;
            r_sqx  <= (2 * A)'(r_ax) * (2 * A)'(r_ax);
            r_sqz  <= (2 * A)'(r_az) * (2 * A)'(r_az);
        end
    end

    // stage c: sum of squares, kinetic numerator
    always_comb begin
        n_c2     = r_c[1];
        n_c2.num = NW'(r_kroot) * NW'(r_c[1].lambda);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[2]    <= n_c2;
            r_rem[0]  <= SW'(r_sqx) + SW'(r_sqz);
            r_root[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar m = 0; m < L; m++) begin : g_sqrt
        localparam int I = L - 1 - m;
        logic [SW-1:0] cand;
        assign cand = (SW'(r_root[m]) << (I + 1)) + (SW'(1) << (2 * I));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c[3+m] <= r_c[2+m];
                if (r_rem[m] >= cand) begin
                    r_rem[m+1]  <= r_rem[m] - cand;
                    r_root[m+1] <= r_root[m] | (L'(1) << I);
                end else begin
                    r_rem[m+1]  <= r_rem[m];
                    r_root[m+1] <= r_root[m];
                end
            end
        end
    end

    // stage d: classify
    always_comb begin
        logic [L-1:0] len;
        len = r_root[L];
        n_cd     = r_c[ST_D-1];
        n_cd.len = len;
        n_cd.sat = (len == '0) || ({{L{1'b0}}, n_cd.num} >= (DW'(len) << QUOT_BITS));
        if (!n_cd.in_patch) begin
            n_cd.mode = MODE_NONE;
        end else if (len < L'(r_still)) begin
            n_cd.mode = MODE_LIFT;
        end else if ((W + 2)'(len) < (W + 2)'(n_cd.slim)) begin
            n_cd.mode = MODE_STATIC;
        end else begin
            n_cd.mode = MODE_KINETIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[ST_D]  <= n_cd;
            r_drem[0]  <= n_cd.num;
            r_q[0]     <= '0;
        end
    end

    // kinetic fraction, one quotient bit per stage
    for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
        localparam int I = QUOT_BITS - 1 - j;
        logic [DW-1:0] dv;
        assign dv = DW'(r_c[ST_D+j].len) << I;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c[ST_D+1+j] <= r_c[ST_D+j];
                if ({{L{1'b0}}, r_drem[j]} >= dv) begin
                    r_drem[j+1] <= NW'({{L{1'b0}}, r_drem[j]} - dv);
                    r_q[j+1]    <= r_q[j] | (QUOT_BITS'(1) << I);
                end else begin
                    r_drem[j+1] <= r_drem[j];
                    r_q[j+1]    <= r_q[j];
                end
            end
        end
    end

    // stage e: scaled corrections
    logic [QUOT_BITS:0] f;
    logic [W:0]         mdx, mdz;
    always_comb begin
        t_carry c;
        c = r_c[ST_E-1];
        if (c.sat || r_q[QUOT_BITS] > QUOT_BITS'(1 << COEF_FRAC)) begin
            f = (QUOT_BITS + 1)'(1 << COEF_FRAC);
        end else begin
            f = (QUOT_BITS + 1)'(r_q[QUOT_BITS]);
        end
        mdx = c.dx[W] ? (W + 1)'(-c.dx) : c.dx;
        mdz = c.dz[W] ? (W + 1)'(-c.dz) : c.dz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[ST_E] <= r_c[ST_E-1];
            r_pcx     <= (W + 18)'(mdx) * (W + 18)'(f);
            r_pcz     <= (W + 18)'(mdz) * (W + 18)'(f);
        end
    end

    // output register
    logic signed [W+2:0] cx, cz, ox, oz;
    always_comb begin
        t_carry c;
        c  = r_c[ST_E];
        cx = $signed({1'b0, r_pcx[W+17:COEF_FRAC]});
        cz = $signed({1'b0, r_pcz[W+17:COEF_FRAC]});
        if (c.dx[W]) cx = -cx;
        if (c.dz[W]) cz = -cz;
        ox = (W + 3)'(c.px) - cx;
        oz = (W + 3)'(c.pz) - cz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mode <= r_c[ST_E].mode;
            case (r_c[ST_E].mode)
                MODE_NONE: begin
                    r_ox <= r_c[ST_E].px;
                    r_oy <= r_c[ST_E].py;
                    r_oz <= r_c[ST_E].pz;
                end
                MODE_LIFT: begin
                    r_ox <= r_c[ST_E].px;
                    r_oy <= '0;
                    r_oz <= r_c[ST_E].pz;
                end
                MODE_STATIC: begin
                    r_ox <= r_c[ST_E].qx;
                    r_oy <= '0;
                    r_oz <= r_c[ST_E].qz;
                end
                default: begin
                    r_ox <= ox[W-1:0];
                    r_oy <= '0;
                    r_oz <= oz[W-1:0];
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/fcf_checker.sv -----
`include "assert_macros.svh"

module fcf_props
    import fcf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [COORD_WIDTH-1:0] o_out_x,
    input logic [COORD_WIDTH-1:0] o_out_y,
    input logic [COORD_WIDTH-1:0] o_out_z,
    input logic [1:0]             o_contact_mode
);

    `FCF_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
    `FCF_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_stall |-> (o_valid && i_stall), "stall without held result")
    `FCF_ASSERT(a_contact_floor, i_clk, i_rst_n,
        (o_valid && o_contact_mode != MODE_NONE) |-> (o_out_y == '0), "contact not on floor")
    `FCF_ASSERT(a_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_x) && $stable(o_out_z)
            && $stable(o_contact_mode)), "held result changed")

endmodule

bind floor_contact_friction_unit fcf_props #(.COORD_WIDTH(COORD_WIDTH)) u_fcf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_x        (o_out_x),
    .o_out_y        (o_out_y),
    .o_out_z        (o_out_z),
    .o_contact_mode (o_contact_mode)
);
